// ===== rtl/sbei_pkg.sv =====
// ---------------------------------------------------------------------------
// sbei_pkg: shared definitions for the segment/box edge intersect core
// Widths, stream field layout, orientation codes and small geometry helpers.
// ---------------------------------------------------------------------------
package sbei_pkg;

    localparam int COORD_BITS = 16;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int CORNER_W   = COORD_BITS + 1;
    localparam int DIFF_W     = COORD_BITS + 2;
    localparam int PROD_W     = 2 * DIFF_W;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_EDGES   = 4;

    // input stream layout, lowest bits first
    localparam int SSX_LSB   = 0;
    localparam int SSY_LSB   = SSX_LSB + COORD_BITS;
    localparam int SEX_LSB   = SSY_LSB + COORD_BITS;
    localparam int SEY_LSB   = SEX_LSB + COORD_BITS;
    localparam int BCX_LSB   = SEY_LSB + COORD_BITS;
    localparam int BCY_LSB   = BCX_LSB + COORD_BITS;
    localparam int BHW_LSB   = BCY_LSB + COORD_BITS;
    localparam int BHH_LSB   = BHW_LSB + HALF_BITS;
    localparam int S_FIELD_W = BHH_LSB + HALF_BITS;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [HALF_BITS-1:0]  half_t;
    typedef logic signed [CORNER_W-1:0]   corner_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;

    typedef enum logic [1:0] {
        ORI_COLLINEAR,
        ORI_CW,
        ORI_CCW
    } orient_t;

    // bounding-range flags for one box edge (c, d) against segment (a, b)
    typedef struct packed {
        logic acb;  // c within range of a..b
        logic adb;  // d within range of a..b
        logic cad;  // a within range of c..d
        logic cbd;  // b within range of c..d
    } within_t;

    function automatic orient_t orient_of(prod_t p, prod_t q);
        orient_t o;
        if (p == q)
            o = ORI_COLLINEAR;
        else if (p > q)
            o = ORI_CW;
        else
            o = ORI_CCW;
        return o;
    endfunction

    // point (px, py) lies within the bounding range of (ax, ay) and (cx, cy)
    function automatic logic in_range(corner_t ax, corner_t ay, corner_t px,
                                      corner_t py, corner_t cx, corner_t cy);
        logic ok_x;
        logic ok_y;
        ok_x = (px <= ax || px <= cx) && (px >= ax || px >= cx);
        ok_y = (py <= ay || py <= cy) && (py >= ay || py >= cy);
        return ok_x && ok_y;
    endfunction

    // corner indices of each edge: bottom, right, top, left
    function automatic logic [1:0] edge_first(int e);
        logic [1:0] k;
        case (e)
            0:       k = 2'd0;
            1:       k = 2'd1;
            2:       k = 2'd2;
            3:       k = 2'd0;
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] edge_second(int e);
        logic [1:0] k;
        case (e)
            0:       k = 2'd1;
            1:       k = 2'd2;
            2:       k = 2'd3;
            3:       k = 2'd3;
            default: k = 2'd1;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/segment_box_edge_intersect_core.sv =====
// ---------------------------------------------------------------------------
// segment_box_edge_intersect_core: segment versus box-edge crossing test
// Reports whether a segment crosses or touches any edge of a centred box.
// ---------------------------------------------------------------------------
// Throughput: one segment/box pair per cycle while m_tready is not held low, through a four-stage pipeline
// (input, corner differences, registered multiplier rank, compare/result).
// Stages collapse bubbles, so a new transfer is taken while a result waits, as long as some stage is empty.
// Reset clears all stage valid flags; payload registers are not reset.
module segment_box_edge_intersect_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_center_x,
    // box_center_y, box_half_w, box_half_h, zero pad
    input  logic [sbei_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, zero pad
    output logic [sbei_pkg::M_TDATA_W-1:0] m_tdata
);
    import sbei_pkg::*;

    // stage valid flags and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    half_t  hw_reg, hh_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ax_reg <= s_tdata[SSX_LSB +: COORD_BITS];
            ay_reg <= s_tdata[SSY_LSB +: COORD_BITS];
            bx_reg <= s_tdata[SEX_LSB +: COORD_BITS];
            by_reg <= s_tdata[SEY_LSB +: COORD_BITS];
            cx_reg <= s_tdata[BCX_LSB +: COORD_BITS];
            cy_reg <= s_tdata[BCY_LSB +: COORD_BITS];
            hw_reg <= s_tdata[BHW_LSB +: HALF_BITS];
            hh_reg <= s_tdata[BHH_LSB +: HALF_BITS];
        end
    end

    // ---------------- stage 2: corners, differences, range flags ----------------
    corner_t ax_w, ay_w, bx_w, by_w;
    corner_t kx_w [NUM_CORNERS];
    corner_t ky_w [NUM_CORNERS];

    diff_t   dsx_next, dsy_next;
    diff_t   ckx_next [NUM_CORNERS];
    diff_t   cky_next [NUM_CORNERS];
    diff_t   edx_next [NUM_EDGES];
    diff_t   edy_next [NUM_EDGES];
    diff_t   eax_next [NUM_EDGES];
    diff_t   eay_next [NUM_EDGES];
    diff_t   ebx_next [NUM_EDGES];
    diff_t   eby_next [NUM_EDGES];
    within_t win_next [NUM_EDGES];

    always_comb
    begin
        corner_t lo_x, hi_x, lo_y, hi_y;
        corner_t c_x, c_y, d_x, d_y;
        ax_w = corner_t'(ax_reg);
        ay_w = corner_t'(ay_reg);
        bx_w = corner_t'(bx_reg);
        by_w = corner_t'(by_reg);
        lo_x = corner_t'(cx_reg) - corner_t'(hw_reg);
        hi_x = corner_t'(cx_reg) + corner_t'(hw_reg);
        lo_y = corner_t'(cy_reg) - corner_t'(hh_reg);
        hi_y = corner_t'(cy_reg) + corner_t'(hh_reg);
        kx_w[0] = lo_x; ky_w[0] = lo_y;
        kx_w[1] = hi_x; ky_w[1] = lo_y;
        kx_w[2] = hi_x; ky_w[2] = hi_y;
        kx_w[3] = lo_x; ky_w[3] = hi_y;

        dsx_next = diff_t'(bx_w) - diff_t'(ax_w);
        dsy_next = diff_t'(by_w) - diff_t'(ay_w);
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            ckx_next[k] = diff_t'(kx_w[k]) - diff_t'(bx_w);
            cky_next[k] = diff_t'(ky_w[k]) - diff_t'(by_w);
        end
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            c_x = kx_w[edge_first(e)];
            c_y = ky_w[edge_first(e)];
            d_x = kx_w[edge_second(e)];
            d_y = ky_w[edge_second(e)];
            edx_next[e] = diff_t'(d_x) - diff_t'(c_x);
            edy_next[e] = diff_t'(d_y) - diff_t'(c_y);
            eax_next[e] = diff_t'(ax_w) - diff_t'(d_x);
            eay_next[e] = diff_t'(ay_w) - diff_t'(d_y);
            ebx_next[e] = diff_t'(bx_w) - diff_t'(d_x);
            eby_next[e] = diff_t'(by_w) - diff_t'(d_y);
            win_next[e].acb = in_range(ax_w, ay_w, c_x, c_y, bx_w, by_w);
            win_next[e].adb = in_range(ax_w, ay_w, d_x, d_y, bx_w, by_w);
            win_next[e].cad = in_range(c_x, c_y, ax_w, ay_w, d_x, d_y);
            win_next[e].cbd = in_range(c_x, c_y, bx_w, by_w, d_x, d_y);
        end
    end

    diff_t   dsx_reg, dsy_reg;
    diff_t   ckx_reg [NUM_CORNERS];
    diff_t   cky_reg [NUM_CORNERS];
    diff_t   edx_reg [NUM_EDGES];
    diff_t   edy_reg [NUM_EDGES];
    diff_t   eax_reg [NUM_EDGES];
    diff_t   eay_reg [NUM_EDGES];
    diff_t   ebx_reg [NUM_EDGES];
    diff_t   eby_reg [NUM_EDGES];
    within_t win2_reg [NUM_EDGES];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            dsx_reg <= dsx_next;
            dsy_reg <= dsy_next;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                ckx_reg[k] <= ckx_next[k];
                cky_reg[k] <= cky_next[k];
            end
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                edx_reg[e]  <= edx_next[e];
                edy_reg[e]  <= edy_next[e];
                eax_reg[e]  <= eax_next[e];
                eay_reg[e]  <= eay_next[e];
                ebx_reg[e]  <= ebx_next[e];
                eby_reg[e]  <= eby_next[e];
                win2_reg[e] <= win_next[e];
            end
        end
    end

    // ---------------- stage 3: cross-product terms ----------------
    prod_t pk_next  [NUM_CORNERS];
    prod_t qk_next  [NUM_CORNERS];
    prod_t pea_next [NUM_EDGES];
    prod_t qea_next [NUM_EDGES];
    prod_t peb_next [NUM_EDGES];
    prod_t qeb_next [NUM_EDGES];

    always_comb
    begin
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            pk_next[k] = prod_t'(dsy_reg) * prod_t'(ckx_reg[k]);
            qk_next[k] = prod_t'(dsx_reg) * prod_t'(cky_reg[k]);
        end
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            pea_next[e] = prod_t'(edy_reg[e]) * prod_t'(eax_reg[e]);
            qea_next[e] = prod_t'(edx_reg[e]) * prod_t'(eay_reg[e]);
            peb_next[e] = prod_t'(edy_reg[e]) * prod_t'(ebx_reg[e]);
            qeb_next[e] = prod_t'(edx_reg[e]) * prod_t'(eby_reg[e]);
        end
    end

    prod_t   pk_reg  [NUM_CORNERS];
    prod_t   qk_reg  [NUM_CORNERS];
    prod_t   pea_reg [NUM_EDGES];
    prod_t   qea_reg [NUM_EDGES];
    prod_t   peb_reg [NUM_EDGES];
    prod_t   qeb_reg [NUM_EDGES];
    within_t win3_reg [NUM_EDGES];

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                pk_reg[k] <= pk_next[k];
                qk_reg[k] <= qk_next[k];
            end
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                pea_reg[e]  <= pea_next[e];
                qea_reg[e]  <= qea_next[e];
                peb_reg[e]  <= peb_next[e];
                qeb_reg[e]  <= qeb_next[e];
                win3_reg[e] <= win2_reg[e];
            end
        end
    end

    // ---------------- stage 4: orientation and result ----------------
    logic hit_next;
    logic hit_reg;

    always_comb
    begin
        orient_t ok [NUM_CORNERS];
        orient_t o1, o2, o3, o4;
        logic    meet;
        for (int k = 0; k < NUM_CORNERS; k++)
            ok[k] = orient_of(pk_reg[k], qk_reg[k]);
        hit_next = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            o1 = ok[edge_first(e)];
            o2 = ok[edge_second(e)];
            o3 = orient_of(pea_reg[e], qea_reg[e]);
            o4 = orient_of(peb_reg[e], qeb_reg[e]);
            meet = (o1 != o2 && o3 != o4)
                || (o1 == ORI_COLLINEAR && win3_reg[e].acb)
                || (o2 == ORI_COLLINEAR && win3_reg[e].adb)
                || (o3 == ORI_COLLINEAR && win3_reg[e].cad)
                || (o4 == ORI_COLLINEAR && win3_reg[e].cbd);
            hit_next = hit_next | meet;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
            hit_reg <= hit_next;
    end

    assign m_tdata = {(M_TDATA_W-1)'(0), hit_reg};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for segment_box_edge_intersect_core
// Streams segment/box pairs into the core, predicts each hit flag with an
// independent orientation-test model and checks every result transfer in
// order. Both stream sides idle and stall at random, with one long output
// hold-off and full drains along the way.
// ---------------------------------------------------------------------------
import sbei_pkg::*;

typedef struct packed {
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t box_center_x;
    coord_t box_center_y;
    half_t  box_half_w;
    half_t  box_half_h;
} pair_t;

typedef struct packed {
    int x;
    int y;
} point_t;

class hit_scoreboard;
    bit expected_hits[$];
    int mismatches;
    int hits_seen;
    int misses_seen;

    function orient_t turn_of(point_t a, point_t b, point_t c);
        longint lhs;
        longint rhs;
        lhs = longint'(b.y - a.y) * longint'(c.x - b.x);
        rhs = longint'(b.x - a.x) * longint'(c.y - b.y);
        if (lhs == rhs)
            return ORI_COLLINEAR;
        return (lhs > rhs) ? ORI_CW : ORI_CCW;
    endfunction

    // p lies within the bounding range of a and c
    function bit within_range(point_t a, point_t p, point_t c);
        return (p.x <= ((a.x > c.x) ? a.x : c.x)) && (p.x >= ((a.x < c.x) ? a.x : c.x)) &&
               (p.y <= ((a.y > c.y) ? a.y : c.y)) && (p.y >= ((a.y < c.y) ? a.y : c.y));
    endfunction

    function bit segments_meet(point_t a, point_t b, point_t c, point_t d);
        orient_t o1;
        orient_t o2;
        orient_t o3;
        orient_t o4;
        o1 = turn_of(a, b, c);
        o2 = turn_of(a, b, d);
        o3 = turn_of(c, d, a);
        o4 = turn_of(c, d, b);
        if (o1 != o2 && o3 != o4)
            return 1'b1;
        // collinear touches
        return (o1 == ORI_COLLINEAR && within_range(a, c, b)) ||
               (o2 == ORI_COLLINEAR && within_range(a, d, b)) ||
               (o3 == ORI_COLLINEAR && within_range(c, a, d)) ||
               (o4 == ORI_COLLINEAR && within_range(c, b, d));
    endfunction

    function bit predict_hit(pair_t p);
        point_t a;
        point_t b;
        point_t lo_lo;
        point_t hi_lo;
        point_t hi_hi;
        point_t lo_hi;
        int     cx;
        int     cy;
        int     hw;
        int     hh;
        a     = '{x: int'(p.seg_start_x), y: int'(p.seg_start_y)};
        b     = '{x: int'(p.seg_end_x), y: int'(p.seg_end_y)};
        cx    = int'(p.box_center_x);
        cy    = int'(p.box_center_y);
        hw    = int'(p.box_half_w);
        hh    = int'(p.box_half_h);
        lo_lo = '{x: cx - hw, y: cy - hh};
        hi_lo = '{x: cx + hw, y: cy - hh};
        hi_hi = '{x: cx + hw, y: cy + hh};
        lo_hi = '{x: cx - hw, y: cy + hh};
        return segments_meet(a, b, lo_lo, hi_lo) || segments_meet(a, b, hi_lo, hi_hi) ||
               segments_meet(a, b, hi_hi, lo_hi) || segments_meet(a, b, lo_lo, lo_hi);
    endfunction

    function void note_pair(pair_t p);
        expected_hits.push_back(predict_hit(p));
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
        bit want;
        if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %02h", $time, data);
            mismatches++;
            return;
        end
        want = expected_hits.pop_front();
        if (want)
            hits_seen++;
        else
            misses_seen++;
        if (data[0] !== want) begin
            $display("%0t: hit mismatch, expected %0b, actual %b", $time, want, data[0]);
            mismatches++;
        end
        if (data[M_TDATA_W-1:1] !== '0) begin
            $display("%0t: pad mismatch, expected 0, actual %b", $time, data[M_TDATA_W-1:1]);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_hits.size();
    endfunction

    function void flag_leftovers();
        if (expected_hits.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
                     $time, expected_hits.size(), expected_hits.size());
            mismatches += expected_hits.size();
        end
    endfunction
endclass

module tb;

    localparam int     CLK_PERIOD   = 10;
    localparam longint TIMEOUT_NS   = 2_000_000;
    localparam int     HOLD_CYCLES  = 60;
    localparam int     DRAIN_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 10;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    hit_scoreboard sb = new();

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_off_req = 1'b0;
    int pairs_sent   = 0;

    segment_box_edge_intersect_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [S_TDATA_W-1:0] pack_pair(pair_t p);
        return {{(S_TDATA_W - S_FIELD_W){1'b0}}, p.box_half_h, p.box_half_w,
                p.box_center_y, p.box_center_x, p.seg_end_y, p.seg_end_x,
                p.seg_start_y, p.seg_start_x};
    endfunction

    function automatic pair_t unpack_pair(logic [S_TDATA_W-1:0] d);
        pair_t p;
        p.seg_start_x  = d[SSX_LSB +: COORD_BITS];
        p.seg_start_y  = d[SSY_LSB +: COORD_BITS];
        p.seg_end_x    = d[SEX_LSB +: COORD_BITS];
        p.seg_end_y    = d[SEY_LSB +: COORD_BITS];
        p.box_center_x = d[BCX_LSB +: COORD_BITS];
        p.box_center_y = d[BCY_LSB +: COORD_BITS];
        p.box_half_w   = d[BHW_LSB +: HALF_BITS];
        p.box_half_h   = d[BHH_LSB +: HALF_BITS];
        return p;
    endfunction

    function automatic pair_t make_pair(int sx, int sy, int ex, int ey,
                                        int cx, int cy, int hw, int hh);
        pair_t p;
        p.seg_start_x  = coord_t'(sx);
        p.seg_start_y  = coord_t'(sy);
        p.seg_end_x    = coord_t'(ex);
        p.seg_end_y    = coord_t'(ey);
        p.box_center_x = coord_t'(cx);
        p.box_center_y = coord_t'(cy);
        p.box_half_w   = half_t'(hw);
        p.box_half_h   = half_t'(hh);
        return p;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    cx;
        int    cy;
        int    hw;
        int    hh;
        int    ax;
        int    ay;
        int    bx;
        int    by;
        int    side;
        cx   = int'($urandom_range(0, 60000)) - 30000;
        cy   = int'($urandom_range(0, 60000)) - 30000;
        // mostly small boxes so that segments land on and around the edges
        hw   = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 32767))
                                             : int'($urandom_range(0, 400));
        hh   = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 32767))
                                             : int'($urandom_range(0, 400));
        side = int'($urandom_range(0, 3));
        ax   = cx + jitter(hw + 60);
        ay   = cy + jitter(hh + 60);
        bx   = cx + jitter(hw + 60);
        by   = cy + jitter(hh + 60);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p.seg_start_x  = coord_t'($urandom);
                p.seg_start_y  = coord_t'($urandom);
                p.seg_end_x    = coord_t'($urandom);
                p.seg_end_y    = coord_t'($urandom);
                p.box_center_x = coord_t'($urandom);
                p.box_center_y = coord_t'($urandom);
                p.box_half_w   = half_t'($urandom);
                p.box_half_h   = half_t'($urandom);
                return p;
            end
            4:
            begin
                // first endpoint on one of the edges
                case (side)
                    0:       begin ax = cx + jitter(hw); ay = cy - hh; end
                    1:       begin ax = cx + hw; ay = cy + jitter(hh); end
                    2:       begin ax = cx + jitter(hw); ay = cy + hh; end
                    default: begin ax = cx - hw; ay = cy + jitter(hh); end
                endcase
            end
            5:
            begin
                // both endpoints on the line through one edge
                if (side[0]) begin
                    ax = (side == 1) ? cx + hw : cx - hw;
                    bx = ax;
                    ay = cy + jitter(2 * hh + 60);
                    by = cy + jitter(2 * hh + 60);
                end else begin
                    ay = (side == 0) ? cy - hh : cy + hh;
                    by = ay;
                    ax = cx + jitter(2 * hw + 60);
                    bx = cx + jitter(2 * hw + 60);
                end
            end
            6:
            begin
                // wholly inside, clear of the edges when both half sizes are nonzero
                ax = cx + ((hw > 1) ? jitter(hw - 1) : 0);
                bx = cx + ((hw > 1) ? jitter(hw - 1) : 0);
                ay = cy + ((hh > 1) ? jitter(hh - 1) : 0);
                by = cy + ((hh > 1) ? jitter(hh - 1) : 0);
            end
            7:
            begin
                if ($urandom_range(0, 1) == 0) begin
                    ax = side[0] ? cx + hw : cx - hw;
                    ay = cy + jitter(hh);
                end
                bx = ax;
                by = ay;
            end
            8:
            begin
                if ($urandom_range(0, 1) == 0)
                    hw = 0;
                if ($urandom_range(0, 1) == 0)
                    hh = 0;
                ax = cx + jitter(hw + 20);
                ay = cy + jitter(hh + 20);
                bx = cx + jitter(hw + 20);
                by = cy + jitter(hh + 20);
            end
            9:
            begin
                ax = side[0] ? cx + hw : cx - hw;
                ay = side[1] ? cy + hh : cy - hh;
            end
            default:
            begin
            end
        endcase
        return make_pair(clamp_coord(ax), clamp_coord(ay), clamp_coord(bx),
                         clamp_coord(by), cx, cy, hw, hh);
    endfunction

    task automatic offer_pair(input pair_t p);
        s_tdata  <= pack_pair(p);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pairs_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic offer_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            offer_pair(random_pair());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // transfer monitor: note inputs before checking outputs of the same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_pair(unpack_pair(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // output side back-pressure
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners of the field ranges, degenerate boxes and segments, touches
        offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        offer_pair(make_pair(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767));
        offer_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        offer_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767));
        offer_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
        offer_pair(make_pair(-1, -1, -1, -1, -1, -1, 32767, 32767));
        offer_pair(make_pair(-200, 5, 200, 5, 0, 0, 100, 50));
        offer_pair(make_pair(-20, -10, 30, 15, 0, 0, 100, 50));
        offer_pair(make_pair(150, 80, 300, 200, 0, 0, 100, 50));
        offer_pair(make_pair(100, 10, 100, 10, 0, 0, 100, 50));
        offer_pair(make_pair(-100, 50, -100, 50, 0, 0, 100, 50));
        offer_pair(make_pair(3, 4, 3, 4, 0, 0, 100, 50));
        offer_pair(make_pair(20, -50, 20, -300, 0, 0, 100, 50));
        offer_pair(make_pair(-300, -50, -50, -50, 0, 0, 100, 50));
        offer_pair(make_pair(150, -50, 400, -50, 0, 0, 100, 50));
        offer_pair(make_pair(-30, -200, 30, 200, 10, 10, 0, 40));
        offer_pair(make_pair(-50, -50, 50, 50, 0, 0, 0, 0));
        offer_pair(make_pair(-50, -49, 50, 51, 0, 0, 0, 0));
        offer_pair(make_pair(90, 60, 110, 40, 0, 0, 100, 50));
        offer_pair(make_pair(91, 60, 111, 40, 0, 0, 100, 50));
        offer_pair(make_pair(-32768, 32767, 32767, -32768, -32768, 32767, 0, 32767));
        wait_drained();

        offer_random(500);

        // stall the output for a long stretch while input keeps coming
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            offer_pair(random_pair());
        wait_drained();

        offer_random(660);

        // closing stretch with no idling on either side
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        repeat (10) @(posedge clk);
        for (int i = 0; i < 600; i++)
            offer_pair(random_pair());
        s_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flag_leftovers();

        $display("Ran %0d segment/box pairs: %0d hits and %0d misses checked,",
                 pairs_sent, sb.hits_seen, sb.misses_seen);
        $display("with edge touches, collinear edges, degenerate boxes and segments.");
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== segment_box_edge_intersect_core.f =====
rtl/sbei_pkg.sv
rtl/segment_box_edge_intersect_core.sv
dv/tb.sv
